/* hw/rtl/spchc_pkg.sv */
// ----------------------------------------------------------------------------
// spchc_pkg
// Shared constants and types for the space packet header and CRC checker.
// ----------------------------------------------------------------------------
package spchc_pkg;

   localparam int HdrLen   = 6;
   localparam int IdxWidth = 17;
   localparam int CrcWidth = 16;

   localparam logic [CrcWidth-1:0] CRC_POLY = 16'h1021;
   localparam logic [CrcWidth-1:0] CRC_INIT = 16'hFFFF;

   localparam logic [IdxWidth-1:0] CRC_HI_OFFSET = 17'd5;

   typedef struct packed {
      logic [2:0]  version;
      logic        type_flag;
      logic        sec_header_present;
      logic [9:0]  apid;
      logic [1:0]  seq_flags;
      logic [13:0] seq_count;
      logic [15:0] data_length;
      logic [15:0] crc_rx;
      logic [15:0] computed_crc;
      logic        crc_match;
   } rsp_fields_type;

endpackage

/* hw/rtl/spchc_req_if.sv */
// ----------------------------------------------------------------------------
// spchc_req_if
// Byte channel into the checker: one packet byte and its start marker.
// ----------------------------------------------------------------------------
interface spchc_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_packet;

   modport source (output valid, output data_byte, output start_of_packet, input ready);
   modport sink (input valid, input data_byte, input start_of_packet, output ready);

endinterface

/* hw/rtl/spchc_rsp_if.sv */
// ----------------------------------------------------------------------------
// spchc_rsp_if
// Result channel out of the checker: decoded header fields and CRC status.
// ----------------------------------------------------------------------------
interface spchc_rsp_if;

   logic        valid;
   logic        ready;
   logic [2:0]  version;
   logic        type_flag;
   logic        sec_header_present;
   logic [9:0]  apid;
   logic [1:0]  seq_flags;
   logic [13:0] seq_count;
   logic [15:0] data_length;
   logic [15:0] crc_rx;
   logic [15:0] computed_crc;
   logic        crc_match;

   modport source (
      output valid, output version, output type_flag, output sec_header_present,
      output apid, output seq_flags, output seq_count, output data_length,
      output crc_rx, output computed_crc, output crc_match, input ready
   );
   modport sink (
      input valid, input version, input type_flag, input sec_header_present,
      input apid, input seq_flags, input seq_count, input data_length,
      input crc_rx, input computed_crc, input crc_match, output ready
   );

endinterface

/* hw/rtl/spchc_crc_byte.sv */
// ----------------------------------------------------------------------------
// spchc_crc_byte
// One byte of CRC-16-CCITT, MSB first, as eight unrolled bit steps.
// ----------------------------------------------------------------------------
module spchc_crc_byte (
   input  logic [spchc_pkg::CrcWidth-1:0] crc_cur,
   input  logic [7:0]                     data,
   output logic [spchc_pkg::CrcWidth-1:0] crc_next
);
   import spchc_pkg::*;

   always_comb begin
      logic [CrcWidth-1:0] c;
      logic                top;
      c = crc_cur;
      for (int k = 0; k < 8; k++) begin
         top = c[CrcWidth-1] ^ data[7-k];
         c   = {c[CrcWidth-2:0], 1'b0};
         if (top) begin
            c = c ^ CRC_POLY;
         end
      end
      crc_next = c;
   end

endmodule

/* hw/rtl/space_packet_header_crc_checker_core.sv */
// ----------------------------------------------------------------------------
// space_packet_header_crc_checker_core
// Result: final byte goes through input register, then result register.
// Throughput: one byte per cycle (single-pass byte CRC) unless results stall.
// Reset: synchronous; clears channel valids and waits for a start marker.
// ----------------------------------------------------------------------------
module space_packet_header_crc_checker_core (
   input logic       clock,
   input logic       reset,
   spchc_req_if.sink   req_chan,
   spchc_rsp_if.source rsp_chan
);
   import spchc_pkg::*;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                in_sop_ff, in_sop_in;

   // packet state
   logic                in_packet_ff, in_packet_in;
   logic [IdxWidth-1:0] byte_index_ff, byte_index_in;
   logic [7:0]          hdr_ff [HdrLen];
   logic [7:0]          hdr_in [HdrLen];
   logic [CrcWidth-1:0] crc_ff, crc_in;
   logic [7:0]          crc_high_ff, crc_high_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_fields_type      rsp_ff, rsp_in;

   logic                advance;
   logic                accept;
   logic                active;
   logic [IdxWidth-1:0] idx;
   logic [CrcWidth-1:0] crc_cur;
   logic [CrcWidth-1:0] crc_next;
   logic [15:0]         len_cur;
   logic [IdxWidth-1:0] len_end;
   logic                in_body;
   logic                is_crc_hi;
   logic                is_final;
   logic                produce;
   logic [15:0]         rx_crc;

   spchc_crc_byte u_crc (
      .crc_cur  (crc_cur),
      .data     (in_byte_ff),
      .crc_next (crc_next)
   );

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign active    = in_sop_ff || in_packet_ff;
   assign idx       = in_sop_ff ? '0 : byte_index_ff;
   assign crc_cur   = in_sop_ff ? CRC_INIT : crc_ff;
   assign len_cur   = {hdr_ff[4], (idx == IdxWidth'(HdrLen - 1)) ? in_byte_ff : hdr_ff[5]};
   assign len_end   = {1'b0, len_cur} + CRC_HI_OFFSET;
   assign in_body   = idx < len_end;
   assign is_crc_hi = idx == len_end;
   assign is_final  = !in_body && !is_crc_hi;
   assign produce   = advance && active && is_final;
   assign rx_crc    = {crc_high_ff, in_byte_ff};

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_sop_in   = in_sop_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.data_byte;
         in_sop_in   = req_chan.start_of_packet;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      in_packet_in  = in_packet_ff;
      byte_index_in = byte_index_ff;
      crc_in        = crc_ff;
      crc_high_in   = crc_high_ff;
      for (int k = 0; k < HdrLen; k++) begin
         hdr_in[k] = hdr_ff[k];
      end
      if (advance && active) begin
         in_packet_in  = !is_final;
         byte_index_in = is_final ? '0 : idx + 1'b1;
         crc_in        = in_body ? crc_next : crc_cur;
         if (is_crc_hi) begin
            crc_high_in = in_byte_ff;
         end
         for (int k = 0; k < HdrLen; k++) begin
            if (idx == IdxWidth'(k)) begin
               hdr_in[k] = in_byte_ff;
            end
         end
      end
   end

   always_comb begin
      rsp_in                    = rsp_ff;
      rsp_valid_in              = rsp_valid_ff && !rsp_chan.ready;
      if (produce) begin
         rsp_valid_in                = 1'b1;
         rsp_in.version              = hdr_ff[0][7:5];
         rsp_in.type_flag            = hdr_ff[0][4];
         rsp_in.sec_header_present   = hdr_ff[0][3];
         rsp_in.apid                 = {hdr_ff[0][1:0], hdr_ff[1]};
         rsp_in.seq_flags            = hdr_ff[2][7:6];
         rsp_in.seq_count            = {hdr_ff[2][5:0], hdr_ff[3]};
         rsp_in.data_length          = {hdr_ff[4], hdr_ff[5]};
         rsp_in.crc_rx               = rx_crc;
         rsp_in.computed_crc         = crc_cur;
         rsp_in.crc_match            = rx_crc == crc_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         in_packet_ff  <= 1'b0;
         byte_index_ff <= '0;
         crc_ff        <= CRC_INIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         in_packet_ff  <= in_packet_in;
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_sop_ff   <= in_sop_in;
      crc_high_ff <= crc_high_in;
      rsp_ff      <= rsp_in;
      for (int k = 0; k < HdrLen; k++) begin
         hdr_ff[k] <= hdr_in[k];
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.version            = rsp_ff.version;
   assign rsp_chan.type_flag          = rsp_ff.type_flag;
   assign rsp_chan.sec_header_present = rsp_ff.sec_header_present;
   assign rsp_chan.apid               = rsp_ff.apid;
   assign rsp_chan.seq_flags          = rsp_ff.seq_flags;
   assign rsp_chan.seq_count          = rsp_ff.seq_count;
   assign rsp_chan.data_length        = rsp_ff.data_length;
   assign rsp_chan.crc_rx             = rsp_ff.crc_rx;
   assign rsp_chan.computed_crc       = rsp_ff.computed_crc;
   assign rsp_chan.crc_match          = rsp_ff.crc_match;

`ifndef ASSERT_OFF
   // idle parser holds a cleared byte position
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !in_packet_ff |-> byte_index_ff == '0)
      else $error("byte position not cleared outside a packet");

   // position never runs past the final byte
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      in_packet_ff && byte_index_ff > IdxWidth'(HdrLen) |->
         byte_index_ff <= {1'b0, hdr_ff[4], hdr_ff[5]} + CRC_HI_OFFSET + 1'b1)
      else $error("byte position beyond packet end");

   // a transaction that yields a result closes the packet
   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      produce |=> !in_packet_ff && rsp_valid_ff)
      else $error("final byte did not close the packet");

   // match flag agrees with the two CRCs
   a_match_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.crc_match == (rsp_ff.crc_rx == rsp_ff.computed_crc))
      else $error("crc match flag inconsistent");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the space packet header and CRC checker. A short
// table of directed bytes covers the header extremes, a zero length packet,
// a packet cut short by a new start marker and stray bytes outside a packet.
// Random packets follow, most of them well formed with good or bad CRCs, some
// cut short and some stray noise. Every byte transaction runs through a local
// predictor; every result transaction is compared field by field against the
// oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

   import spchc_pkg::*;

   localparam int QuietLimit  = 4000;
   localparam int RandItems   = 1300;
   localparam int SettleCycles = 20;

   typedef struct packed {
      logic [7:0]  data;
      logic        sop;
      logic        known;
      logic [2:0]  version;
      logic        type_flag;
      logic        sec_header_present;
      logic [9:0]  apid;
      logic [1:0]  seq_flags;
      logic [13:0] seq_count;
      logic [15:0] data_length;
      logic [15:0] crc_rx;
   } byte_row_type;

   // known rows carry the header fields of the result that byte completes
   localparam byte_row_type ByteTable [0:19] = '{
      '{8'h55, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'hFF, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b1, 3'd7, 1'b1, 1'b1, 10'd1023, 2'd3, 14'd16383, 16'd0, 16'h00FF},
      '{8'h3C, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h12, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h34, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h04, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'h01, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'hAB, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000},
      '{8'hCD, 1'b0, 1'b1, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd1, 16'hABCD},
      '{8'h99, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 10'd0, 2'd0, 14'd0, 16'd0, 16'h0000}
   };

   logic clock;
   logic reset;

   spchc_req_if req_bus ();
   spchc_rsp_if rsp_bus ();

   space_packet_header_crc_checker_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predictor state
   logic                pkt_active;
   logic [IdxWidth-1:0] pkt_pos;
   logic [7:0]          hdr [HdrLen];
   logic [15:0]         crc_run;
   logic [7:0]          crc_hi_byte;

   rsp_fields_type pending_results [$];

   int  error_count;
   int  bytes_sent;
   int  results_predicted;
   int  results_checked;
   int  crc_matches;
   int  packets_cut;
   int  quiet_cycles;
   bit  last_made;
   bit  calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] d);
      logic top;
      for (int k = 7; k >= 0; k--) begin
         top = c[15] ^ d[k];
         c = {c[14:0], 1'b0};
         if (top) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic s, output bit made);
      logic [15:0]         len;
      logic [IdxWidth-1:0] crc_end;
      rsp_fields_type      r;
      made = 1'b0;
      if (s) begin
         if (pkt_active) begin
            packets_cut++;
         end
         pkt_active  = 1'b1;
         pkt_pos     = '0;
         for (int k = 0; k < HdrLen; k++) hdr[k] = 8'h00;
         crc_run     = CRC_INIT;
         crc_hi_byte = 8'h00;
      end
      if (!pkt_active) begin
         return;
      end
      if (pkt_pos < HdrLen) begin
         hdr[pkt_pos[2:0]] = b;
      end
      len     = {hdr[4], hdr[5]};
      crc_end = {1'b0, len} + CRC_HI_OFFSET;
      if (pkt_pos < CRC_HI_OFFSET || pkt_pos < crc_end) begin
         crc_run = crc16_update(crc_run, b);
         pkt_pos = pkt_pos + 1'b1;
      end else if (pkt_pos == crc_end) begin
         crc_hi_byte = b;
         pkt_pos     = pkt_pos + 1'b1;
      end else begin
         r.version            = hdr[0][7:5];
         r.type_flag          = hdr[0][4];
         r.sec_header_present = hdr[0][3];
         r.apid               = {hdr[0][1:0], hdr[1]};
         r.seq_flags          = hdr[2][7:6];
         r.seq_count          = {hdr[2][5:0], hdr[3]};
         r.data_length        = len;
         r.crc_rx             = {crc_hi_byte, b};
         r.computed_crc       = crc_run;
         r.crc_match          = (r.crc_rx == crc_run);
         pending_results.push_back(r);
         results_predicted++;
         pkt_active = 1'b0;
         pkt_pos    = '0;
         made       = 1'b1;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.data_byte       <= b;
      req_bus.start_of_packet <= s;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_byte(b, s, last_made);
      bytes_sent++;
   endtask

   task automatic send_packet(input int len, input bit good_crc, input bit cut_short);
      logic [7:0]  pkt [$];
      logic [15:0] crc;
      int          n;
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(len[15:8]);
      pkt.push_back(len[7:0]);
      for (int k = 6; k < len + 5; k++) pkt.push_back(8'($urandom_range(0, 255)));
      crc = CRC_INIT;
      for (int k = 0; k < len + 5; k++) crc = crc16_update(crc, pkt[k]);
      // with length zero the high crc byte is the low length byte itself
      if (len > 0) begin
         pkt.push_back(good_crc ? crc[15:8] : 8'($urandom_range(0, 255)));
      end
      pkt.push_back(good_crc ? crc[7:0] : 8'($urandom_range(0, 255)));
      n = cut_short ? $urandom_range(1, pkt.size() - 1) : pkt.size();
      for (int k = 0; k < n; k++) send_byte(pkt[k], k == 0);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // result side: random stalls and field by field comparison
   initial begin : result_sink
      int             stall_left;
      rsp_fields_type want;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with no header pending");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (want.crc_match) begin
                  crc_matches++;
               end
               check_field("version", 32'(want.version), 32'(rsp_bus.version));
               check_field("type_flag", 32'(want.type_flag), 32'(rsp_bus.type_flag));
               check_field("sec_header_present", 32'(want.sec_header_present),
                           32'(rsp_bus.sec_header_present));
               check_field("apid", 32'(want.apid), 32'(rsp_bus.apid));
               check_field("seq_flags", 32'(want.seq_flags), 32'(rsp_bus.seq_flags));
               check_field("seq_count", 32'(want.seq_count), 32'(rsp_bus.seq_count));
               check_field("data_length", 32'(want.data_length),
                           32'(rsp_bus.data_length));
               check_field("crc_rx", 32'(want.crc_rx), 32'(rsp_bus.crc_rx));
               check_field("computed_crc", 32'(want.computed_crc),
                           32'(rsp_bus.computed_crc));
               check_field("crc_match", 32'(want.crc_match), 32'(rsp_bus.crc_match));
            end
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QuietLimit);
      $error("no transaction for %0d cycles", QuietLimit);
      $display("tb: errors");
      $finish;
   end

   initial begin : stimulus
      rsp_fields_type last;
      int             r;
      int             len;
      error_count       = 0;
      bytes_sent        = 0;
      results_predicted = 0;
      results_checked   = 0;
      crc_matches       = 0;
      packets_cut       = 0;
      calm              = 1'b0;
      pkt_active        = 1'b0;
      pkt_pos           = '0;
      for (int k = 0; k < HdrLen; k++) hdr[k] = 8'h00;
      crc_run           = CRC_INIT;
      crc_hi_byte       = 8'h00;
      reset                   = 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.data_byte       <= 8'h00;
      req_bus.start_of_packet <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (ByteTable[i]) begin
         send_byte(ByteTable[i].data, ByteTable[i].sop);
         if (ByteTable[i].known) begin
            if (!last_made) begin
               $error("table row %0d completes no packet", i);
               error_count++;
            end else begin
               last = pending_results[pending_results.size() - 1];
               last.version            = ByteTable[i].version;
               last.type_flag          = ByteTable[i].type_flag;
               last.sec_header_present = ByteTable[i].sec_header_present;
               last.apid               = ByteTable[i].apid;
               last.seq_flags          = ByteTable[i].seq_flags;
               last.seq_count          = ByteTable[i].seq_count;
               last.data_length        = ByteTable[i].data_length;
               last.crc_rx             = ByteTable[i].crc_rx;
               last.crc_match          = (last.crc_rx == last.computed_crc);
               pending_results[pending_results.size() - 1] = last;
            end
         end
      end

      // random packets
      while (bytes_sent < RandItems) begin
         calm = ($urandom_range(0, 99) < 15);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            len = $urandom_range(0, 6);
         end else if (r < 95) begin
            len = $urandom_range(7, 30);
         end else if (r < 99) begin
            len = $urandom_range(31, 200);
         end else begin
            len = $urandom_range(201, 600);
         end
         r = $urandom_range(0, 99);
         if (r < 80) begin
            send_packet(len, 1'($urandom_range(0, 1)), 1'b0);
         end else if (r < 92) begin
            send_packet(len, 1'b1, 1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("tb: %0d byte transactions, %0d headers checked, %0d with matching crc",
               bytes_sent, results_checked, crc_matches);
      $display("tb: %0d packets cut short by a start marker", packets_cut);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
